FILE: hdl/assert_macros.svh
// Assertion macros included by the framer/checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the block is out of reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/nsfc_pkg.sv
package nsfc_pkg;

  localparam logic [7:0] CH_DOLLAR       = 8'h24;
  localparam logic [7:0] CH_STAR         = 8'h2A;
  localparam logic [7:0] CH_CR           = 8'h0D;
  localparam logic [7:0] CH_FILL         = 8'hFF;
  localparam logic [7:0] CH_NUL          = 8'h00;
  localparam logic [2:0] PREFIX_LEN      = 3'd6;
  localparam logic [7:0] MAX_CHARS_RESET = 8'd99;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_MAX_CHARS = 1'b0;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_GNGGA   = 2'd1,
    KIND_OTHER   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_CR     = 2'd0,
    CAUSE_DOLLAR = 2'd1,
    CAUSE_LIMIT  = 2'd2
  } cause_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] computed;
    logic [7:0] received;
    logic [7:0] count;
    cause_e     cause;
  } result_t;

  // Expected byte at each position of the "$GNGGA" prefix.
  function automatic logic [7:0] prefix_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'b0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      r = {1'b1, d[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

FILE: hdl/nmea_sentence_framer_checker.sv
// Frames NMEA 0183 sentences from a raw receiver byte stream and checks their
// checksums. One byte beat is taken every clock cycle while the input is not
// stalled, and the sentence state is updated in the same cycle. A finished
// sentence is registered into the output register, or into the skid register
// while the output is held. A two-entry output buffer (output register plus
// skid register) lets the input keep running while a result waits, so the
// input stalls only when both entries are full. The max_chars limit is written
// through the APB port at byte address 0 and reads back there; it resets to 99.
module nmea_sentence_framer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    sentence_kind_o,
  output logic [7:0]                    computed_checksum_o,
  output logic [7:0]                    received_checksum_o,
  output logic [7:0]                    char_count_o,
  output logic [1:0]                    end_cause_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nsfc_pkg::PADDR_W-1:0]  paddr,
  input  logic [nsfc_pkg::PDATA_W-1:0]  pwdata,
  output logic [nsfc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import nsfc_pkg::*;

  logic [7:0] max_chars_q, max_chars_d;

  logic       hunting_q, hunting_d;
  logic [7:0] count_q, count_d;
  logic [7:0] xor_q, xor_d;
  logic       star_q, star_d;
  logic       hex_done_q, hex_done_d;
  logic [7:0] hex_q, hex_d;
  logic [2:0] prefix_q, prefix_d;
  logic       text_end_q, text_end_d;

  logic       in_acc;
  logic       out_fire;
  logic [7:0] limit;
  logic [4:0] nib;
  logic       emit;
  cause_e     cause;
  result_t    res_new;

  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       skid_valid_q, skid_valid_d;
  result_t    skid_q, skid_d;

  // Configuration port.
  assign pready = 1'b1;

  always_comb begin
    max_chars_d = max_chars_q;
    if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_CHARS)) begin
      max_chars_d = pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_CHARS) begin
      prdata = {{(PDATA_W-8){1'b0}}, max_chars_q};
    end
  end

  // Sentence state update.
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign limit    = (max_chars_q == 8'd0) ? 8'd1 : max_chars_q;
  assign nib      = hex_nibble(data_byte_i);

  always_comb begin
    hunting_d  = hunting_q;
    count_d    = count_q;
    xor_d      = xor_q;
    star_d     = star_q;
    hex_done_d = hex_done_q;
    hex_d      = hex_q;
    prefix_d   = prefix_q;
    text_end_d = text_end_q;
    emit       = 1'b0;
    cause      = CAUSE_CR;

    if (in_acc) begin
      if (hunting_q) begin
        if (data_byte_i == CH_DOLLAR) begin
          hunting_d  = 1'b0;
          count_d    = 8'd1;
          xor_d      = 8'd0;
          star_d     = 1'b0;
          hex_done_d = 1'b0;
          hex_d      = 8'd0;
          prefix_d   = 3'd1;
          text_end_d = 1'b0;
        end
      end else if (data_byte_i == CH_CR) begin
        emit      = 1'b1;
        cause     = CAUSE_CR;
        hunting_d = 1'b1;
      end else if (data_byte_i == CH_DOLLAR) begin
        emit       = 1'b1;
        cause      = CAUSE_DOLLAR;
        count_d    = 8'd1;
        xor_d      = 8'd0;
        star_d     = 1'b0;
        hex_done_d = 1'b0;
        hex_d      = 8'd0;
        prefix_d   = 3'd1;
        text_end_d = 1'b0;
      end else if (count_q >= limit) begin
        emit      = 1'b1;
        cause     = CAUSE_LIMIT;
        hunting_d = 1'b1;
      end else if (data_byte_i != CH_FILL) begin
        count_d = count_q + 8'd1;
        if (!text_end_q) begin
          if (data_byte_i == CH_NUL) begin
            text_end_d = 1'b1;
          end else begin
            if ((count_q < {5'd0, PREFIX_LEN}) && (prefix_q == count_q[2:0]) &&
                (data_byte_i == prefix_char(count_q[2:0]))) begin
              prefix_d = prefix_q + 3'd1;
            end
            if (!star_q) begin
              if (data_byte_i == CH_STAR) begin
                star_d = 1'b1;
              end else begin
                xor_d = xor_q ^ data_byte_i;
              end
            end else if (!hex_done_q) begin
              if (!nib[4]) begin
                hex_done_d = 1'b1;
              end else begin
                hex_d = {hex_q[3:0], nib[3:0]};
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    res_new.kind     = KIND_INVALID;
    if (star_q && (xor_q == hex_q)) begin
      res_new.kind = (prefix_q == PREFIX_LEN) ? KIND_GNGGA : KIND_OTHER;
    end
    res_new.computed = xor_q;
    res_new.received = star_q ? hex_q : 8'd0;
    res_new.count    = count_q;
    res_new.cause    = cause;
  end

  // Output register and skid register.
  assign in_stall_o = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_d       = res_new;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res_new;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q  <= MAX_CHARS_RESET;
      hunting_q    <= 1'b1;
      count_q      <= 8'd0;
      xor_q        <= 8'd0;
      star_q       <= 1'b0;
      hex_done_q   <= 1'b0;
      hex_q        <= 8'd0;
      prefix_q     <= 3'd0;
      text_end_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      max_chars_q  <= max_chars_d;
      hunting_q    <= hunting_d;
      count_q      <= count_d;
      xor_q        <= xor_d;
      star_q       <= star_d;
      hex_done_q   <= hex_done_d;
      hex_q        <= hex_d;
      prefix_q     <= prefix_d;
      text_end_q   <= text_end_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o         = out_valid_q;
  assign sentence_kind_o     = out_q.kind;
  assign computed_checksum_o = out_q.computed;
  assign received_checksum_o = out_q.received;
  assign char_count_o        = out_q.count;
  assign end_cause_o         = out_q.cause;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_pready_high, clk_i, pready, "pready low")
  `ASSERT_CLKD(a_skid_needs_out, clk_i, rst_ni, !skid_valid_q || out_valid_q, "skid full while output empty")
  `ASSERT_CLKD(a_count_nonzero, clk_i, rst_ni, !out_valid_q || (out_q.count != 8'd0), "zero count")
  `ASSERT_CLKD(a_valid_matches, clk_i, rst_ni,
               !out_valid_q || (out_q.kind == KIND_INVALID) || (out_q.computed == out_q.received),
               "valid kind with checksum mismatch")
  `ASSERT_CLKD(a_hunt_stays, clk_i, rst_ni,
               (in_acc && hunting_q && (data_byte_i != CH_DOLLAR)) |=> hunting_q,
               "left hunting without a dollar")

endmodule

FILE: tb/nmea_sentence_framer_checker_tb.sv
`timescale 1ns / 1ps

module nmea_sentence_framer_checker_tb;
  import nsfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 275;
  localparam logic [PADDR_W-1:0] ADDR_MAX_CHARS = PADDR_W'(REG_MAX_CHARS) << 2;
  localparam logic [PADDR_W-1:0] ADDR_SPARE = ADDR_MAX_CHARS + PADDR_W'(4);
  localparam logic [47:0] GNGGA_TEXT = "$GNGGA";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] sentence_kind_o;
  logic [7:0] computed_checksum_o;
  logic [7:0] received_checksum_o;
  logic [7:0] char_count_o;
  logic [1:0] end_cause_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Predicted framer state.
  logic [7:0] max_len = MAX_CHARS_RESET;
  logic in_hunt = 1'b1;
  logic [7:0] n_stored = 8'd0;
  logic [7:0] sum_xor = 8'd0;
  logic got_star = 1'b0;
  logic hex_stop = 1'b0;
  logic [7:0] hex_val = 8'd0;
  logic [2:0] gngga_match = 3'd0;
  logic nul_seen = 1'b0;

  result_t pending_sentences[$];

  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned n_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_checked = 0;

  nmea_sentence_framer_checker DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sentence_kind_o    (sentence_kind_o),
    .computed_checksum_o(computed_checksum_o),
    .received_checksum_o(received_checksum_o),
    .char_count_o       (char_count_o),
    .end_cause_o        (end_cause_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("[nmea_sentence_framer_checker] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic open_sentence();
    in_hunt = 1'b0;
    n_stored = 8'd1;
    sum_xor = 8'd0;
    got_star = 1'b0;
    hex_stop = 1'b0;
    hex_val = 8'd0;
    gngga_match = 3'd1;
    nul_seen = 1'b0;
  endtask

  task automatic close_sentence(input cause_e cause);
    result_t r;
    r.kind = KIND_INVALID;
    if (got_star && sum_xor == hex_val) begin
      r.kind = (gngga_match == PREFIX_LEN) ? KIND_GNGGA : KIND_OTHER;
    end
    r.computed = sum_xor;
    r.received = got_star ? hex_val : 8'd0;
    r.count = n_stored;
    r.cause = cause;
    pending_sentences.push_back(r);
  endtask

  task automatic frame_byte(input logic [7:0] b);
    logic [7:0] lim;
    int idx;
    lim = (max_len == 8'd0) ? 8'd1 : max_len;
    if (in_hunt) begin
      if (b == CH_DOLLAR) open_sentence();
    end else if (b == CH_CR) begin
      close_sentence(CAUSE_CR);
      in_hunt = 1'b1;
    end else if (b == CH_DOLLAR) begin
      close_sentence(CAUSE_DOLLAR);
      open_sentence();
    end else if (n_stored >= lim) begin
      close_sentence(CAUSE_LIMIT);
      in_hunt = 1'b1;
    end else if (b != CH_FILL) begin
      idx = n_stored;
      n_stored = n_stored + 8'd1;
      if (!nul_seen) begin
        if (b == CH_NUL) begin
          nul_seen = 1'b1;
        end else begin
          if (idx < PREFIX_LEN && gngga_match == 3'(idx)
              && b == GNGGA_TEXT[8*(5-idx) +: 8]) begin
            gngga_match = gngga_match + 3'd1;
          end
          if (!got_star) begin
            if (b == CH_STAR) got_star = 1'b1;
            else sum_xor = sum_xor ^ b;
          end else if (!hex_stop) begin
            if (b >= 8'h30 && b <= 8'h39) begin
              hex_val = {hex_val[3:0], b[3:0]};
            end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
              hex_val = {hex_val[3:0], b[3:0] + 4'd9};
            end else begin
              hex_stop = 1'b1;
            end
          end
        end
      end
    end
  endtask

  // Called right after a rising edge; returns right after the edge that took the beat.
  task automatic send_byte(input logic [7:0] b);
    if (in_gaps_on && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frame_byte(b);
    n_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_sentence(input string s);
    send_text(s);
    send_byte(CH_CR);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sentences.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_MAX_CHARS) max_len = data[7:0];
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== PDATA_W'(max_len)) begin
      $error("max_chars readback expected %0d actual %0d", max_len, prdata);
      n_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_max_chars(input logic [7:0] v);
    wait_idle();
    apb_write(ADDR_MAX_CHARS, PDATA_W'(v));
    apb_read_check(ADDR_MAX_CHARS);
  endtask

  task automatic test_sentence_kinds();
    send_byte(CH_FILL);
    send_byte(CH_CR);
    send_byte(CH_NUL);
    send_text("A");
    send_sentence("$GNGGA*48");
    send_sentence("$GNGGA*1248");
    send_text("$a*61");
    send_text("$b");
    send_byte(CH_FILL);
    send_sentence("*62Z0");
    send_sentence("$GNGGA*00");
    send_sentence("$x");
    send_sentence("$*");
    send_text("$A");
    send_byte(CH_NUL);
    send_sentence("*41");
    send_text("$");
    send_byte(8'hFE);
    send_byte(8'h80);
    send_sentence("*7e");
    wait_idle();
  endtask

  task automatic test_register_map();
    apb_read_check(ADDR_MAX_CHARS);
    apb_write(ADDR_SPARE, PDATA_W'(3));
    apb_read_check(ADDR_MAX_CHARS);
    send_sentence("$ABCDEF");
    wait_idle();
  endtask

  task automatic test_length_limit();
    set_max_chars(8'd1);
    send_text("$A$");
    send_byte(CH_CR);
    set_max_chars(8'd0);
    send_text("$");
    send_byte(CH_FILL);
    send_text("$");
    send_byte(CH_NUL);
    set_max_chars(8'd2);
    send_text("$A$A");
    send_byte(CH_CR);
    set_max_chars(8'd255);
    send_text("$");
    repeat (255) send_text("B");
    set_max_chars(8'd254);
    send_text("$");
    repeat (254) send_text("C");
    send_byte(CH_CR);
    set_max_chars(MAX_CHARS_RESET);
  endtask

  task automatic test_backpressure();
    wait_idle();
    in_gaps_on = 1'b0;
    hold_req = ~hold_req;
    repeat (40) send_sentence("$K*4B");
    in_gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic random_phase(input int unsigned budget);
    logic [7:0] frame[$];
    logic [7:0] sum;
    logic [7:0] b;
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      frame.delete();
      sum = 8'd0;
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(255)));
      end else begin
        frame.push_back(CH_DOLLAR);
        if ($urandom_range(1)) begin
          for (int i = 1; i < PREFIX_LEN; i++) begin
            frame.push_back(GNGGA_TEXT[8*(5-i) +: 8]);
            sum ^= GNGGA_TEXT[8*(5-i) +: 8];
          end
        end
        repeat ($urandom_range(0, 12)) begin
          if ($urandom_range(99) < 15) begin
            b = 8'($urandom_range(255));
          end else if ($urandom_range(3) == 0) begin
            b = ",";
          end else begin
            b = 8'($urandom_range(8'h20, 8'h7E));
            if (b == CH_DOLLAR || b == CH_STAR) b = ",";
          end
          frame.push_back(b);
          if (b != CH_FILL) sum ^= b;
        end
        if ($urandom_range(99) < 80) begin
          if ($urandom_range(99) < 20) sum ^= 8'($urandom_range(1, 255));
          frame.push_back(CH_STAR);
          frame.push_back(hex_char(sum[7:4], $urandom_range(1)));
          frame.push_back(hex_char(sum[3:0], $urandom_range(1)));
        end
        if ($urandom_range(99) < 80) frame.push_back(CH_CR);
      end
      foreach (frame[i]) send_byte(frame[i]);
      sent += frame.size();
    end
  endtask

  task automatic test_random();
    random_phase(PHASE_BYTES);
    set_max_chars(8'($urandom_range(20, 80)));
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    random_phase(PHASE_BYTES);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    set_max_chars($urandom_range(1) ? 8'd254 : 8'd255);
    random_phase(PHASE_BYTES);
    set_max_chars(8'($urandom_range(1, 12)));
    random_phase(PHASE_BYTES);
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= out_gaps_on && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sentences.size() == 0) begin
        $error("result beat with no sentence expected");
        n_errors++;
      end else begin
        want = pending_sentences.pop_front();
        n_checked++;
        if (sentence_kind_o !== want.kind) begin
          $error("sentence_kind expected %0d actual %0d", want.kind, sentence_kind_o);
          n_errors++;
        end
        if (computed_checksum_o !== want.computed) begin
          $error("computed_checksum expected %02h actual %02h", want.computed,
                 computed_checksum_o);
          n_errors++;
        end
        if (received_checksum_o !== want.received) begin
          $error("received_checksum expected %02h actual %02h", want.received,
                 received_checksum_o);
          n_errors++;
        end
        if (char_count_o !== want.count) begin
          $error("char_count expected %0d actual %0d", want.count, char_count_o);
          n_errors++;
        end
        if (end_cause_o !== want.cause) begin
          $error("end_cause expected %0d actual %0d", want.cause, end_cause_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sentence_kinds();
    test_register_map();
    test_length_limit();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Run covered all sentence kinds and end causes, limits 0 to 255 and a long");
    $display("output hold: %0d bytes sent, %0d sentences checked.", n_bytes, n_checked);
    if (n_errors == 0) begin
      $display("[nmea_sentence_framer_checker] OK");
    end else begin
      $display("[nmea_sentence_framer_checker] ERROR");
    end
    $finish;
  end

endmodule
